### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Operation codes and character constants for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_LAST    = 8'h7F;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

endpackage

`default_nettype wire

### rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode character store with a cursor, scrolling and a clear sweep.
// ----------------------------------------------------------------------------
// Usage: a command is transferred at a rising edge where start is high and
// busy is low. op selects put character, clear screen, read one cell or no
// operation. Each command yields exactly one result, shown for one cycle
// with done high; the receiver cannot stall, so it must take it then.
// Latency and throughput: a put that does not scroll, and the no operation
// command, give their result in the next cycle and leave busy low, so one
// command per cycle is accepted. A read passes through S_READ, as the cell
// memory has one read port with a registered output. A put that scrolls
// walks the memory once, copying (ROWS-1)*COLUMNS cells and blanking COLUMNS
// cells. A clear blanks every cell. The length of those sweeps is set by the
// single write port.
// Reset: the cursor goes home and a clearing pass blanks all COLUMNS*ROWS
// cells of the memory; busy stays high through it and no result is given.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer import tccw_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  bg_color,
  input  wire logic [3:0]  fg_color,
  input  wire logic [10:0] read_address,
  output logic             done,
  output logic [6:0]       out_column,
  output logic [4:0]       out_row,
  output logic [10:0]      cursor_location,
  output logic [15:0]      cell_data,
  output logic             scrolled
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_WIDTH);
  // Wide enough for a column plus a full tab step before the wrap check.
  localparam int CW     = $clog2(COLUMNS + TAB_WIDTH);

  localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [PH_W-1:0]   LAST_PH   = PH_W'(TAB_WIDTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COPY,
    S_FILL
  } state_t;

  state_t            state;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  // Column modulo the tab width, kept in step with cur_col so a tab needs
  // no division.
  logic [PH_W-1:0]   phase;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wr_ptr;
  logic              rd_pend;
  logic              rd_ok;
  logic              clr_report;

  logic [ADDR_W-1:0] loc;
  logic [CW-1:0]     col_e;
  logic [PH_W-1:0]   ph_e;
  logic              row_inc;
  logic              printable;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [PH_W-1:0]   phase_next;
  logic              scroll_req;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  // Linear cell index of the cursor, also sent out as the cursor location.
  assign loc             = ADDR_W'(cur_row) * COL_STEP + ADDR_W'(cur_col);
  assign cursor_location = 11'(loc);
  assign out_column      = 7'(cur_col);
  assign out_row         = 5'(cur_row);
  assign busy            = (state != S_IDLE);
  assign printable       = (char_code >= CH_SPACE) && (char_code <= CH_LAST);

  // Cursor movement for a put. Control bytes are decoded first, then a
  // column past the right edge wraps, then a row past the bottom scrolls.
  always_comb begin
    col_e   = CW'(cur_col);
    ph_e    = phase;
    row_inc = 1'b0;
    priority if (char_code == CH_BS) begin
      if (cur_col != '0) begin
        col_e = col_e - CW'(1);
        ph_e  = (phase == '0) ? LAST_PH : phase - PH_W'(1);
      end
    end else if (char_code == CH_TAB) begin
      col_e = col_e + CW'(TAB_WIDTH) - CW'(phase);
      ph_e  = '0;
    end else if (char_code == CH_CR) begin
      col_e = '0;
      ph_e  = '0;
    end else if (char_code == CH_LF) begin
      col_e   = '0;
      ph_e    = '0;
      row_inc = 1'b1;
    end else if (printable) begin
      col_e = col_e + CW'(1);
      ph_e  = (phase == LAST_PH) ? '0 : phase + PH_W'(1);
    end else begin
      col_e = CW'(cur_col);
    end

    if (col_e >= CW'(COLUMNS)) begin
      col_next   = '0;
      phase_next = '0;
      row_inc    = 1'b1;
    end else begin
      col_next   = COL_W'(col_e);
      phase_next = ph_e;
    end

    scroll_req = row_inc && (cur_row == LAST_ROW);
    row_next   = (row_inc && !scroll_req) ? cur_row + ROW_W'(1) : cur_row;
  end

  // Memory port steering. The scroll copy reads one row ahead and writes
  // in the next cycle, so a write never lands on a cell still to be read.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = BLANK_CELL;
    ram_raddr = ADDR_W'(read_address);
    unique case (state)
      S_IDLE: begin
        if (start && (op_t'(op) == OP_PUT) && printable) begin
          ram_we    = 1'b1;
          ram_waddr = loc;
          ram_wdata = {bg_color, fg_color, char_code};
        end
      end
      S_COPY: begin
        ram_raddr = (cnt == COPY_END) ? '0 : cnt + COL_STEP;
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr;
          ram_wdata = ram_rdata;
        end
      end
      S_CLEAR, S_FILL: begin
        ram_we = 1'b1;
      end
      S_READ: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      phase      <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
      clr_report <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cell_data <= '0;
            scrolled  <= 1'b0;
            rd_pend   <= 1'b0;
            cnt       <= '0;
            unique case (op_t'(op))
              OP_PUT: begin
                cur_col <= col_next;
                cur_row <= row_next;
                phase   <= phase_next;
                if (scroll_req) begin
                  done  <= 1'b0;
                  state <= S_COPY;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_CLEAR: begin
                cur_col    <= '0;
                cur_row    <= '0;
                phase      <= '0;
                clr_report <= 1'b1;
                done       <= 1'b0;
                state      <= S_CLEAR;
              end
              OP_READ: begin
                rd_ok <= (32'(read_address) < 32'(CELLS));
                done  <= 1'b0;
                state <= S_READ;
              end
              OP_NONE: begin
                done <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_READ: begin
          cell_data <= rd_ok ? ram_rdata : '0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_COPY: begin
          done <= 1'b0;
          if (cnt == COPY_END) begin
            // The last copy write happens in this cycle; the bottom row
            // is blanked from here on.
            rd_pend <= 1'b0;
            state   <= S_FILL;
          end else begin
            rd_pend <= 1'b1;
            wr_ptr  <= cnt;
            cnt     <= cnt + ADDR_W'(1);
          end
        end
        S_FILL: begin
          if (cnt == LAST_CELL) begin
            scrolled <= 1'b1;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            done <= 1'b0;
            cnt  <= cnt + ADDR_W'(1);
          end
        end
        S_CLEAR: begin
          if (cnt == LAST_CELL) begin
            done       <= clr_report;
            clr_report <= 1'b0;
            cnt        <= '0;
            state      <= S_IDLE;
          end else begin
            done <= 1'b0;
            cnt  <= cnt + ADDR_W'(1);
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/tccw_ram.sv
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks on command acceptance and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tccw_checker import tccw_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  op,
  input wire logic        done,
  input wire logic [15:0] cell_data,
  input wire logic        scrolled
);

  logic accept;
  logic none_acc;
  logic clear_acc;
  logic read_acc;
  logic none_ok;

  assign accept    = start && !busy;
  assign none_acc  = accept && (op == OP_NONE);
  assign clear_acc = accept && (op == OP_CLEAR);
  assign read_acc  = accept && (op == OP_READ);
  assign none_ok   = done && (cell_data == 16'h0000) && !scrolled;

  // A result is only ever given once the block is free again.
  `ASSERT_IMPLIES(a_done_not_busy, clk, rst, done, !busy)

  // The no-operation command answers in the next cycle with empty payload.
  `ASSERT_NEXT(a_none_result, clk, rst, none_acc, none_ok)

  // A clear always walks the memory before answering.
  `ASSERT_NEXT(a_clear_busy, clk, rst, clear_acc, busy && !done)

  // A read keeps busy high while it waits on the memory, then reports without a scroll.
  `ASSERT_NEXT(a_read_timing, clk, rst, read_acc, busy && !done ##1 done && !scrolled)

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .op        (op),
  .done      (done),
  .cell_data (cell_data),
  .scrolled  (scrolled)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console character writer. Commands go in
// through the start/busy handshake, every result is checked against a
// cycle-free model of the screen store and cursor kept in the bench.
// ----------------------------------------------------------------------------

module tb_top;
  import tccw_pkg::*;

  // Screen geometry used both for the block's parameters and for the model.
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_STOP    = 8;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

  // A scroll or a clear sweeps the whole store, so it is the slowest command.
  // The limit covers every command being that slow, the longest sender gap on
  // top, and the clearing pass after reset, several times over.
  localparam int SLOWEST_COMMAND = CELL_COUNT + 64;
  localparam int CYCLE_LIMIT     = 5000 * SLOWEST_COMMAND;
  localparam int SETTLE_CYCLES   = CELL_COUNT + 16;

  // One result as the block reports it after a command.
  typedef struct packed {
    logic [6:0]  column;
    logic [4:0]  row;
    logic [10:0] location;
    logic [15:0] cell_word;
    logic        scroll;
  } console_report_t;

  // Clock and reset. Reset is high from time zero and released once.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Block inputs, all known from the first instant.
  logic        start        = 1'b0;
  op_t         op           = OP_NONE;
  logic [7:0]  char_code    = 8'h00;
  logic [3:0]  bg_color     = 4'h0;
  logic [3:0]  fg_color     = 4'h0;
  logic [10:0] read_address = 11'd0;

  // Block outputs.
  logic        busy;
  logic        done;
  logic [6:0]  out_column;
  logic [4:0]  out_row;
  logic [10:0] cursor_location;
  logic [15:0] cell_data;
  logic        scrolled;

  text_console_char_writer #(
    .COLUMNS  (SCREEN_COLS),
    .ROWS     (SCREEN_ROWS),
    .TAB_WIDTH(TAB_STOP)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .char_code      (char_code),
    .bg_color       (bg_color),
    .fg_color       (fg_color),
    .read_address   (read_address),
    .done           (done),
    .out_column     (out_column),
    .out_row        (out_row),
    .cursor_location(cursor_location),
    .cell_data      (cell_data),
    .scrolled       (scrolled)
  );

  // --------------------------------------------------------------------------
  // Screen model. The bench keeps its own copy of every cell and the cursor,
  // and steps it once per accepted command.
  // --------------------------------------------------------------------------
  logic [15:0] screen_image [CELL_COUNT];
  int          cur_col;
  int          cur_row;

  // Results that the model has produced and the block has not yet reported,
  // oldest first.
  console_report_t pending_reports [$];

  int failure_count   = 0;
  int sender_idle_pct = 0;

  function automatic void blank_screen_image();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_image[i] = BLANK_CELL;
    end
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Applies one command to the model and returns the result it must give.
  function automatic console_report_t console_step(op_t cmd, logic [7:0] ch,
                                                   logic [3:0] bg, logic [3:0] fg,
                                                   logic [10:0] addr);
    console_report_t rep;
    rep = '0;
    case (cmd)
      OP_PUT: begin
        if (ch == CH_BS) begin
          // Backspace stops at the left edge.
          if (cur_col != 0) cur_col = cur_col - 1;
        end else if (ch == CH_TAB) begin
          cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_LF) begin
          cur_col = 0;
          cur_row = cur_row + 1;
        end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
          screen_image[cur_row * SCREEN_COLS + cur_col] = {bg, fg, ch};
          cur_col = cur_col + 1;
        end
        // Other control bytes and all bytes with the top bit set fall
        // through untouched, but wrap and scroll are still evaluated.
        if (cur_col >= SCREEN_COLS) begin
          cur_col = 0;
          cur_row = cur_row + 1;
        end
        if (cur_row >= SCREEN_ROWS) begin
          // Move every row up by one and blank the bottom row.
          for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++) begin
            screen_image[i] = screen_image[i + SCREEN_COLS];
          end
          for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < CELL_COUNT; i++) begin
            screen_image[i] = BLANK_CELL;
          end
          cur_row    = SCREEN_ROWS - 1;
          rep.scroll = 1'b1;
        end
      end
      OP_CLEAR: begin
        blank_screen_image();
      end
      OP_READ: begin
        // Addresses past the last cell read as zero.
        if (addr < CELL_COUNT) rep.cell_word = screen_image[addr];
      end
      default: begin
        // The spare opcode only reports the cursor.
      end
    endcase
    rep.column   = cur_col[6:0];
    rep.row      = cur_row[4:0];
    rep.location = 11'(cur_row * SCREEN_COLS + cur_col);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------

  // Holds start low for a number of cycles. Callers never pass zero, so a
  // following command never raises start in the step that lowered it.
  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Presents one command and waits for the edge that transfers it. The model
  // is stepped at that edge, so reads see exactly the commands before them.
  // Start is left high: a command that follows at once keeps it high.
  task automatic send_command(op_t cmd, logic [7:0] ch, logic [3:0] bg,
                              logic [3:0] fg, logic [10:0] addr);
    start        <= 1'b1;
    op           <= cmd;
    char_code    <= ch;
    bg_color     <= bg;
    fg_color     <= fg;
    read_address <= addr;
    do @(posedge clk); while (busy);
    pending_reports.push_back(console_step(cmd, ch, bg, fg, addr));
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      // Mostly short gaps, now and then a long one.
      pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(4, 40)
                                               : $urandom_range(1, 3));
    end
  endtask

  // Put with the unused address field randomized.
  task automatic put_char(logic [7:0] ch, logic [3:0] bg, logic [3:0] fg);
    send_command(OP_PUT, ch, bg, fg, 11'($urandom_range(0, 2047)));
  endtask

  // Read with the unused character and color fields randomized.
  task automatic read_cell(logic [10:0] addr);
    send_command(OP_READ, 8'($urandom), 4'($urandom), 4'($urandom), addr);
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_for_reports();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  function automatic logic [7:0] random_printable();
    return 8'($urandom_range(CH_SPACE, CH_LAST));
  endfunction

  // Character mix for random puts: mostly text with line breaks, plus every
  // control byte and bytes with the top bit set.
  function automatic logic [7:0] random_put_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 62)      return random_printable();
    else if (sel < 74) return CH_LF;
    else if (sel < 79) return CH_TAB;
    else if (sel < 84) return CH_BS;
    else if (sel < 88) return CH_CR;
    else if (sel < 94) return 8'($urandom_range(0, 31));
    else               return 8'($urandom_range(128, 255));
  endfunction

  // Read addresses: often on the cursor row where recent writes land, else
  // the bottom row, anywhere on screen, or past the end.
  function automatic logic [10:0] random_read_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      return 11'(cur_row * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
    else if (sel < 5)
      return 11'($urandom_range((SCREEN_ROWS - 1) * SCREEN_COLS, CELL_COUNT - 1));
    else if (sel < 6)
      return 11'($urandom_range(CELL_COUNT, 2047));
    else if (sel < 7)
      return 11'($urandom_range(0, 2047));
    else
      return 11'($urandom_range(0, CELL_COUNT - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // The store comes out of reset blank; reads past the end give zero; the
  // spare opcode only reports the home cursor.
  task automatic test_after_reset();
    read_cell(11'd0);
    read_cell(11'(CELL_COUNT - 1));
    read_cell(11'(CELL_COUNT));
    read_cell(11'h7FF);
    send_command(OP_NONE, 8'hFF, 4'hF, 4'hF, 11'h7FF);
  endtask

  // Both ends of the printable range and of the colors, then bytes that must
  // be ignored: a low control byte, the smallest and largest negative bytes
  // and zero.
  task automatic test_printable_and_ignored();
    put_char(CH_SPACE, 4'h0, 4'h0);
    put_char(CH_LAST, 4'hF, 4'hF);
    put_char(8'h1F, 4'h5, 4'hA);
    put_char(8'h80, 4'hA, 4'h5);
    put_char(8'hFF, 4'hF, 4'hF);
    put_char(8'h00, 4'h0, 4'h0);
    read_cell(11'd0);
    read_cell(11'd1);
  endtask

  // Backspace down to and at the left edge, tab from a stop and from between
  // stops, carriage return and line feed.
  task automatic test_cursor_controls();
    put_char(CH_BS, 4'h1, 4'h2);
    put_char(CH_BS, 4'h1, 4'h2);
    put_char(CH_BS, 4'h1, 4'h2);
    put_char(CH_TAB, 4'h3, 4'h4);
    put_char(CH_TAB, 4'h3, 4'h4);
    put_char(8'h78, 4'h6, 4'h9);
    put_char(CH_TAB, 4'h3, 4'h4);
    put_char(CH_CR, 4'h7, 4'h8);
    put_char(CH_LF, 4'h8, 4'h7);
  endtask

  // A clear after a write blanks the screen and homes the cursor.
  task automatic test_clear();
    put_char(8'h41, 4'hC, 4'h3);
    send_command(OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                 11'($urandom_range(0, 2047)));
    read_cell(11'(SCREEN_COLS));
    read_cell(11'd0);
  endtask

  // Lines of text and tabs with no line break, so the cursor runs off the
  // right edge: both a character in the last column and a tab from the last
  // stop wrap to the next row.
  task automatic test_line_wrap();
    int wraps;
    wraps = 0;
    put_char(CH_CR, 4'($urandom), 4'($urandom));
    while (wraps < 4) begin
      put_char(($urandom_range(0, 3) == 0) ? CH_TAB : random_printable(),
               4'($urandom), 4'($urandom));
      if (cur_col == 0) begin
        wraps++;
        read_cell(11'(cur_row * SCREEN_COLS - 1));
      end
    end
  endtask

  // Lines of random text ended by line feeds, from a clear screen down past
  // the bottom so that the later lines each scroll. Reads check that earlier
  // lines moved up and the bottom row came back blank.
  task automatic test_scroll_sequence();
    int line_len;
    send_command(OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                 11'($urandom_range(0, 2047)));
    for (int line = 0; line < SCREEN_ROWS + 8; line++) begin
      line_len = $urandom_range(0, 12);
      for (int k = 0; k < line_len; k++) begin
        put_char(random_printable(), 4'($urandom), 4'($urandom));
      end
      put_char(CH_LF, 4'($urandom), 4'($urandom));
      if (cur_row == SCREEN_ROWS - 1) begin
        read_cell(11'((SCREEN_ROWS - 2) * SCREEN_COLS + $urandom_range(0, 12)));
        read_cell(11'((SCREEN_ROWS - 1) * SCREEN_COLS + $urandom_range(0, 12)));
      end
    end
  endtask

  // Free mix of every command with random fields.
  task automatic test_random_traffic(int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 999);
      if (sel < 760)
        put_char(random_put_byte(), 4'($urandom), 4'($urandom));
      else if (sel < 930)
        read_cell(random_read_address());
      else if (sel < 940)
        send_command(OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                     11'($urandom_range(0, 2047)));
      else
        send_command(OP_NONE, 8'($urandom), 4'($urandom), 4'($urandom),
                     11'($urandom_range(0, 2047)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking. The block cannot be stalled, so every cycle with done
  // high is one result transfer and is compared with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    console_report_t want;
    if (!rst && done === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with no command outstanding");
        failure_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_column !== want.column) begin
          $error("out_column: expected %0d, actual %0d", want.column, out_column);
          failure_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, actual %0d", want.row, out_row);
          failure_count++;
        end
        if (cursor_location !== want.location) begin
          $error("cursor_location: expected %0d, actual %0d",
                 want.location, cursor_location);
          failure_count++;
        end
        if (cell_data !== want.cell_word) begin
          $error("cell_data: expected 0x%04h, actual 0x%04h", want.cell_word, cell_data);
          failure_count++;
        end
        if (scrolled !== want.scroll) begin
          $error("scrolled: expected %0b, actual %0b", want.scroll, scrolled);
          failure_count++;
        end
      end
    end
  end

  // Guard against a hang: a stuck busy or a lost result ends the run here.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    blank_screen_image();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The block clears its store after reset with busy high; the first
    // command simply waits for it. Sender idles lightly at first.
    sender_idle_pct = 16;
    test_after_reset();
    test_printable_and_ignored();
    test_cursor_controls();
    test_clear();
    test_line_wrap();
    test_scroll_sequence();
    test_random_traffic(250);

    // Hold off until the block has caught up, then idle heavily.
    wait_for_reports();
    sender_idle_pct = 59;
    test_random_traffic(250);

    wait_for_reports();
    sender_idle_pct = 0;
    test_line_wrap();
    test_random_traffic(250);

    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failure_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
